// ===== hdl/ndft_pkg.sv =====
`timescale 1ns / 1ps

package ndft_pkg;

    localparam int TabAmpBits = 17;
    localparam real TwoPi = 6.283185307179586;

    localparam logic [1:0] REG_NUM_DIMS = 2'd0;
    localparam logic [1:0] REG_INVERSE  = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef logic [2*TabAmpBits-1:0] qtab_entry_t;

    // round(65536*cos) and round(65536*sin) for angle j/2^pb turns, first quadrant
    function automatic qtab_entry_t quarter_entry(input int j, input int pb);
        real theta;
        real cv;
        real sv;
        int  ci;
        int  si;
        theta = TwoPi * real'(j) * (2.0 ** (-real'(pb)));
        cv    = 65536.0 * $cos(theta);
        sv    = 65536.0 * $sin(theta);
        ci    = $rtoi(cv + 0.5);
        si    = $rtoi(sv + 0.5);
        return {TabAmpBits'(ci), TabAmpBits'(si)};
    endfunction

endpackage

// ===== hdl/ndft_ram.sv =====
`timescale 1ns / 1ps

module ndft_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 4096
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/nonuniform_dft_engine_top.sv =====
`timescale 1ns / 1ps
// Load transaction: s_ready stays high while idle, so loads run back to back.
// Evaluate transaction: per stored sample the read, dims dot, drain, table, cos/sin and four
// complex states (dims = num_dims with 0 as 1), on the single shared 32x32 multiplier (dot
// terms, then four complex terms). s_ready is low until the result is presented and rises
// with m_valid; empty sets skip to output, which stalls while the last result waits on m_ready.
// aresetn synchronous active low: sample count, drop flag, control cleared, config to defaults.
module nonuniform_dft_engine_top #(
    parameter int MAX_SAMPLES = 4096,
    parameter int PHASE_BITS  = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic               s_first_sample,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic signed [31:0] s_value_real,
    input  logic signed [31:0] s_value_imag,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_out_real,
    output logic signed [47:0] m_out_imag,
    output logic               m_last,
    output logic               m_samples_dropped
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int QB = PHASE_BITS - 2;
    localparam int QN = 1 << QB;
    localparam int TB = ndft_pkg::TabAmpBits;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_DOT   = 4'd2;
    localparam logic [3:0] ST_DRAIN = 4'd3;
    localparam logic [3:0] ST_ROM   = 4'd4;
    localparam logic [3:0] ST_CS    = 4'd5;
    localparam logic [3:0] ST_M0    = 4'd6;
    localparam logic [3:0] ST_M1    = 4'd7;
    localparam logic [3:0] ST_M2    = 4'd8;
    localparam logic [3:0] ST_M3    = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [2:0] TAG_NONE   = 3'd0;
    localparam logic [2:0] TAG_DOT    = 3'd1;
    localparam logic [2:0] TAG_RE_ADD = 3'd2;
    localparam logic [2:0] TAG_RE_SUB = 3'd3;
    localparam logic [2:0] TAG_IM_ADD = 3'd4;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          num_dims_reg;
    logic                inverse_reg;
    logic [1:0]          dims_reg;
    logic                inv_eval_reg;
    logic [CW-1:0]       count_reg;
    logic                drop_reg;
    logic [AW-1:0]       idx_reg;
    logic [1:0]          d_reg;
    logic [31:0]         k_reg [3];
    logic                last_pt_reg;
    logic [31:0]         dot_reg;
    logic [63:0]         acc_re_reg, acc_im_reg;
    logic signed [63:0]  prod_reg;
    logic [2:0]          tag_reg, tag_next;
    logic [2*TB-1:0]     rom_q_reg;
    logic [1:0]          quad_reg;
    logic signed [17:0]  c_reg, s_reg;

    logic signed [31:0]  op_a, op_b;
    logic [159:0]        ram_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [2*TB-1:0]     qtab [QN];

    logic                in_acc, load_acc, eval_acc, out_free, last_sample;
    logic [CW-1:0]       eff_count;
    logic signed [17:0]  cq, sq, c_val, s_val;

    for (genvar g = 0; g < QN; g++) begin : g_qtab
        localparam logic [2*TB-1:0] ENTRY = ndft_pkg::quarter_entry(g, PHASE_BITS);
        assign qtab[g] = ENTRY;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign load_acc  = in_acc && (s_action == ndft_pkg::ACT_LOAD);
    assign eval_acc  = in_acc && (s_action == ndft_pkg::ACT_EVAL);
    assign out_free  = !m_valid || m_ready;
    assign eff_count = s_first_sample ? '0 : count_reg;
    assign ram_we    = load_acc && (eff_count != CW'(MAX_SAMPLES));
    assign ram_waddr = eff_count[AW-1:0];
    assign last_sample = ((CW'(idx_reg) + CW'(1)) == count_reg);

    ndft_ram #(
        .WIDTH (160),
        .DEPTH (MAX_SAMPLES)
    ) u_samples (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_value_imag, s_value_real, s_coord_z, s_coord_y, s_coord_x}),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // quadrant fold, then sign of sine by direction
    always_comb begin
        cq = 18'(rom_q_reg[2*TB-1:TB]);
        sq = 18'(rom_q_reg[TB-1:0]);
        case (quad_reg)
            2'd0:    begin c_val = cq;  s_val = sq;  end
            2'd1:    begin c_val = -sq; s_val = cq;  end
            2'd2:    begin c_val = -cq; s_val = -sq; end
            default: begin c_val = sq;  s_val = -cq; end
        endcase
        if (!inv_eval_reg) begin
            s_val = -s_val;
        end
    end

    // shared multiplier operand select
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        tag_next = TAG_NONE;
        case (state_reg)
            ST_DOT: begin
                op_a     = k_reg[d_reg];
                op_b     = ram_rdata[32*d_reg +: 32];
                tag_next = TAG_DOT;
            end
            ST_M0: begin
                op_a     = ram_rdata[127:96];
                op_b     = 32'(c_reg);
                tag_next = TAG_RE_ADD;
            end
            ST_M1: begin
                op_a     = ram_rdata[159:128];
                op_b     = 32'(s_reg);
                tag_next = TAG_RE_SUB;
            end
            ST_M2: begin
                op_a     = ram_rdata[127:96];
                op_b     = 32'(s_reg);
                tag_next = TAG_IM_ADD;
            end
            ST_M3: begin
                op_a     = ram_rdata[159:128];
                op_b     = 32'(c_reg);
                tag_next = TAG_IM_ADD;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (eval_acc) begin
                    state_next = (count_reg == '0) ? ST_OUT : ST_READ;
                end
            end
            ST_READ:  state_next = ST_DOT;
            ST_DOT:   state_next = (d_reg == dims_reg - 2'd1) ? ST_DRAIN : ST_DOT;
            ST_DRAIN: state_next = ST_ROM;
            ST_ROM:   state_next = ST_CS;
            ST_CS:    state_next = ST_M0;
            ST_M0:    state_next = ST_M1;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = last_sample ? ST_FIN : ST_READ;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            num_dims_reg <= 2'd1;
            inverse_reg  <= 1'b0;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            m_valid      <= 1'b0;
            tag_reg      <= TAG_NONE;
        end else begin
            state_reg <= state_next;
            tag_reg   <= tag_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ndft_pkg::REG_NUM_DIMS) begin
                    num_dims_reg <= cfg_data;
                end else if (cfg_index == ndft_pkg::REG_INVERSE) begin
                    inverse_reg <= cfg_data[0];
                end
            end
            if (load_acc) begin
                if (ram_we) begin
                    count_reg <= eff_count + CW'(1);
                    drop_reg  <= s_first_sample ? 1'b0 : drop_reg;
                end else begin
                    count_reg <= eff_count;
                    drop_reg  <= 1'b1;
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= op_a * op_b;
        rom_q_reg <= qtab[dot_reg[31-2 -: QB]];
        quad_reg  <= dot_reg[31:30];
        if (state_reg == ST_CS) begin
            c_reg <= c_val;
            s_reg <= s_val;
        end
        if (eval_acc) begin
            k_reg[0]     <= s_coord_x;
            k_reg[1]     <= s_coord_y;
            k_reg[2]     <= s_coord_z;
            last_pt_reg  <= s_last_point;
            dims_reg     <= (num_dims_reg == 2'd0) ? 2'd1 : num_dims_reg;
            inv_eval_reg <= inverse_reg;
            idx_reg      <= '0;
            acc_re_reg   <= '0;
            acc_im_reg   <= '0;
        end else begin
            case (tag_reg)
                TAG_RE_ADD: acc_re_reg <= acc_re_reg + prod_reg;
                TAG_RE_SUB: acc_re_reg <= acc_re_reg - prod_reg;
                TAG_IM_ADD: acc_im_reg <= acc_im_reg + prod_reg;
                default: begin
                end
            endcase
        end
        if (state_reg == ST_READ) begin
            dot_reg <= '0;
            d_reg   <= 2'd0;
        end else begin
            if (tag_reg == TAG_DOT) begin
                dot_reg <= dot_reg + prod_reg[31:0];
            end
            if (state_reg == ST_DOT) begin
                d_reg <= d_reg + 2'd1;
            end
        end
        if (state_reg == ST_M3 && !last_sample) begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (state_reg == ST_OUT && out_free) begin
            m_out_real        <= acc_re_reg[63:16];
            m_out_imag        <= acc_im_reg[63:16];
            m_last            <= last_pt_reg;
            m_samples_dropped <= drop_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_drop_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(drop_reg) |-> $past(load_acc))
        else $error("drop flag set without a load transaction");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DOT || state_reg == ST_M0) |-> (CW'(idx_reg) < count_reg))
        else $error("sample read beyond stored set");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not presented");
`endif

endmodule
